// ===== src/fmul_pkg.sv =====
// Shared constants and types of the single-precision multiplier.
package fmul_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned ExpW   = 8;
    localparam int unsigned FracW  = 23;
    localparam int unsigned SigW   = FracW + 1;
    localparam int unsigned ProdW  = 2 * SigW;
    localparam int unsigned EW     = 11;
    localparam int unsigned ShW    = 6;

    localparam logic [WordW-1:0] QNAN_WORD = 32'hFFC0_0000;
    localparam logic [WordW-1:0] QUIET_BIT = 32'h0040_0000;
    localparam logic [WordW-1:0] INF_MAG   = 32'h7F80_0000;
    localparam logic signed [EW-1:0] EXP_BIAS   = 11'sd127;
    localparam logic signed [EW-1:0] EXP_MAX    = 11'sd255;
    localparam logic signed [EW-1:0] UFLOW_SPAN = 11'sd48;

    typedef struct packed {
        logic is_spec;
        logic is_zero;
    } fmul_ctl_t;

endpackage

// ===== src/float32_multiplier_unit.sv =====
// Top level of the pipelined single-precision multiplier.
//
// Usage: present two binary32 words on s_operand_a and s_operand_b with
// s_valid; the request is taken when s_valid and s_ready are both high.
// The product appears on m_product with m_valid and is handed over when
// m_ready is high.
// Throughput: one request per cycle while the output is not stalled, through
// four register stages (decode and 24x24 multiply, leading-zero count,
// normalising shift, round and pack).
// Special operands (NaN, zero, infinity) are decided in the first stage and
// ride the pipe beside the arithmetic path.
// Reset (aresetn low, synchronous) clears every stage valid bit; payload
// registers keep whatever they held.
// When the receiver stalls, the whole pipe holds: s_ready falls while the
// output register is full and not taken, so nothing is lost or repeated.
module float32_multiplier_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fmul_pkg::WordW-1:0]    s_operand_a,
    input  logic [fmul_pkg::WordW-1:0]    s_operand_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fmul_pkg::WordW-1:0]    m_product
);
    import fmul_pkg::*;

    logic adv;

    // stage 1 decode
    logic             sa, sb, za, zb, ia, ib, na, nb;
    logic [ExpW-1:0]  ea, eb;
    logic [FracW-1:0] fa, fb;
    logic [SigW-1:0]  ma, mb;
    logic [ExpW-1:0]  ea_adj, eb_adj;

    logic                   v1_reg, v1_next;
    fmul_ctl_t              ctl1_reg, ctl1_next;
    logic [WordW-1:0]       word1_reg, word1_next;
    logic                   sign1_reg, sign1_next;
    logic signed [EW-1:0]   e1_reg, e1_next;
    logic [ProdW-1:0]       m1_reg, m1_next;

    logic                   v2_reg;
    fmul_ctl_t              ctl2_reg;
    logic [WordW-1:0]       word2_reg;
    logic                   sign2_reg;
    logic signed [EW-1:0]   e2_reg, e2_next;
    logic [ProdW-1:0]       m2_reg, m2_next;
    logic [ShW-1:0]         s2_reg, s2_next;
    logic [ShW-1:0]         lz;

    logic                   v3_reg;
    fmul_ctl_t              ctl3_reg, ctl3_next;
    logic [WordW-1:0]       word3_reg;
    logic                   sign3_reg;
    logic signed [EW-1:0]   e3_reg;
    logic [ProdW-1:0]       m3_reg, m3_next;
    logic [ShW-1:0]         rs3_reg, rs3_next;
    logic signed [EW-1:0]   neg_e;

    logic                   v4_reg;
    logic [WordW-1:0]       prod4_reg, prod4_next;

    // advance the pipe unless the output register is full and stalled
    assign adv     = !v4_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = v4_reg;
    assign m_product = prod4_reg;

    // stage 1: classify operands, pick special results, multiply significands
    always_comb begin
        sa = s_operand_a[31];
        sb = s_operand_b[31];
        ea = s_operand_a[30:23];
        eb = s_operand_b[30:23];
        fa = s_operand_a[22:0];
        fb = s_operand_b[22:0];
        za = (ea == '0) && (fa == '0);
        zb = (eb == '0) && (fb == '0);
        ia = (ea == '1) && (fa == '0);
        ib = (eb == '1) && (fb == '0);
        na = (ea == '1) && (fa != '0);
        nb = (eb == '1) && (fb != '0);
        sign1_next = sa ^ sb;
        ctl1_next.is_zero = 1'b0;
        ctl1_next.is_spec = 1'b1;
        priority if ((za && ib) || (ia && zb)) begin
            word1_next = QNAN_WORD;
        end else if (nb) begin
            word1_next = s_operand_b | QUIET_BIT;
        end else if (na) begin
            word1_next = s_operand_a | QUIET_BIT;
        end else if (za || zb) begin
            word1_next = {sign1_next, 31'd0};
        end else if (ia || ib) begin
            word1_next = {sign1_next, 31'd0} | INF_MAG;
        end else begin
            word1_next = '0;
            ctl1_next.is_spec = 1'b0;
        end
        // subnormals: hidden bit clear, exponent taken as one
        ma = {(ea != '0), fa};
        mb = {(eb != '0), fb};
        ea_adj = (ea == '0) ? 8'd1 : ea;
        eb_adj = (eb == '0) ? 8'd1 : eb;
        e1_next = $signed({3'b000, ea_adj}) + $signed({3'b000, eb_adj}) - EXP_BIAS;
        m1_next = ma * mb;
        v1_next = s_valid;
    end

    // stage 2: leading-zero count from bit 46 down, choose normalising shift
    always_comb begin
        lz = '0;
        for (int i = 0; i < ProdW - 1; i++) begin
            if (m1_reg[i]) begin
                lz = ShW'(ProdW - 2 - i);
            end
        end
        if (m1_reg[ProdW-1]) begin
            m2_next = m1_reg >> 1;
            e2_next = e1_reg + 11'sd1;
            s2_next = '0;
        end else if (m1_reg[ProdW-2]) begin
            m2_next = m1_reg;
            e2_next = e1_reg;
            s2_next = '0;
        end else begin
            m2_next = m1_reg;
            // at least one step, at most until the exponent reaches zero, but one step if it is not positive
            if (e1_reg < 11'sd1) begin
                s2_next = ShW'(1);
            end else if (e1_reg > $signed({{(EW-ShW){1'b0}}, lz})) begin
                s2_next = lz;
            end else begin
                s2_next = e1_reg[ShW-1:0];
            end
            e2_next = e1_reg - $signed({{(EW-ShW){1'b0}}, s2_next});
        end
    end

    // stage 3: apply shift, flag deep underflow as zero, work out the underflow shift
    always_comb begin
        m3_next = m2_reg << s2_reg;
        neg_e   = 11'sd1 - e2_reg;
        ctl3_next = ctl2_reg;
        rs3_next  = '0;
        if (!ctl2_reg.is_spec && (e2_reg + UFLOW_SPAN < 11'sd0)) begin
            ctl3_next.is_zero = 1'b1;
        end else if (e2_reg <= 11'sd0) begin
            rs3_next = neg_e[ShW-1:0];
        end
    end

    fmul_round u_round (
        .ctl       (ctl3_reg),
        .spec_word (word3_reg),
        .sign      (sign3_reg),
        .expo      (e3_reg),
        .mant      (m3_reg),
        .rshift    (rs3_reg),
        .product   (prod4_next)
    );

    // valid bits: clear on reset, advance together with the payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload: hold while stalled
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl1_reg  <= ctl1_next;
            word1_reg <= word1_next;
            sign1_reg <= sign1_next;
            e1_reg    <= e1_next;
            m1_reg    <= m1_next;
            ctl2_reg  <= ctl1_reg;
            word2_reg <= word1_reg;
            sign2_reg <= sign1_reg;
            e2_reg    <= e2_next;
            m2_reg    <= m2_next;
            s2_reg    <= s2_next;
            ctl3_reg  <= ctl3_next;
            word3_reg <= word2_reg;
            sign3_reg <= sign2_reg;
            e3_reg    <= e2_reg;
            m3_reg    <= m3_next;
            rs3_reg   <= rs3_next;
            prod4_reg <= prod4_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a normalised item has no bit above 46 after the shift
    a_norm_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !ctl3_reg.is_spec && !ctl3_reg.is_zero) |-> !m3_reg[ProdW-1])
        else $error("normalised significand overflowed bit 46");

    // positive exponent implies a leading one at bit 46
    a_norm_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !ctl3_reg.is_spec && !ctl3_reg.is_zero && e3_reg > 11'sd0)
        |-> m3_reg[ProdW-2])
        else $error("normal result lacks its leading one");

    // underflow shift only for non-positive exponents
    a_uflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && rs3_reg != '0) |-> (e3_reg <= 11'sd0))
        else $error("underflow shift with positive exponent");

    // a stalled output keeps the pipe frozen
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !m_ready) |=> ($stable(v3_reg) && m_valid))
        else $error("pipe moved during a stall");
`endif

endmodule

// ===== src/fmul_round.sv =====
// Final stage logic: special and zero results, guard rounding, overflow, underflow shift and packing.
module fmul_round (
    input  fmul_pkg::fmul_ctl_t                        ctl,
    input  logic [fmul_pkg::WordW-1:0]                 spec_word,
    input  logic                                       sign,
    input  logic signed [fmul_pkg::EW-1:0]             expo,
    input  logic [fmul_pkg::ProdW-1:0]                 mant,
    input  logic [fmul_pkg::ShW-1:0]                   rshift,
    output logic [fmul_pkg::WordW-1:0]                 product
);
    import fmul_pkg::*;

    logic [SigW:0]          rnd;
    logic signed [EW-1:0]   exp_rnd;
    logic [FracW-1:0]       frac_rnd;
    logic [ProdW-1:0]       sub_m;

    always_comb begin
        rnd      = {1'b0, mant[ProdW-2:FracW]} + {{SigW{1'b0}}, mant[FracW-1]};
        exp_rnd  = expo + {{(EW-1){1'b0}}, rnd[SigW]};
        frac_rnd = rnd[SigW] ? rnd[SigW-1:1] : rnd[FracW-1:0];
        sub_m    = mant >> rshift;
        priority if (ctl.is_spec) begin
            product = spec_word;
        end else if (ctl.is_zero) begin
            product = {sign, {(WordW-1){1'b0}}};
        end else if (expo >= EXP_MAX) begin
            product = {sign, 31'd0} | INF_MAG;
        end else if (expo > 11'sd0) begin
            if (exp_rnd >= EXP_MAX) begin
                product = {sign, 31'd0} | INF_MAG;
            end else begin
                product = {sign, exp_rnd[ExpW-1:0], frac_rnd};
            end
        end else begin
            product = {sign, {ExpW{1'b0}}, sub_m[ProdW-3:FracW]};
        end
    end

endmodule
